// File: sv/ldec_pkg.sv
package ldec_pkg;

	// field widths
	localparam int TARGET_W = 40;
	localparam int BRIGHT_W = 8;
	localparam int TIME_W   = 32;
	localparam int FACTOR_W = 16;
	localparam int LIGHT_W  = 24;
	localparam int STATUS_W = 3;
	localparam int DOSE_W   = 48;
	localparam int CFG_W    = 40;
	localparam int INDEX_W  = 2;

	// lux * factor, then times elapsed ms
	localparam int LT_W     = LIGHT_W + FACTOR_W;
	localparam int ACC_W    = LT_W + TIME_W;
	// Q16.8 lux times Q2.14 factor leaves 22 fraction bits
	localparam int FRAC_SH  = 22;
	localparam int DELTA_W  = ACC_W - FRAC_SH;

	// percent arithmetic
	localparam int PCT_W    = 4;
	localparam int PROD_W   = PCT_W + BRIGHT_W;
	localparam int REM_W    = 48;
	localparam int RECIP10  = 52429;
	localparam int RECIP_SH = 19;
	localparam int QUO_W    = PROD_W + 17;
	localparam logic [PCT_W-1:0]    PCT_FULL_SPAN = 4'd10;
	localparam logic [BRIGHT_W-1:0] MIN_BRIGHT    = 8'd10;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_RUNNING = 3'd0;
	localparam status_t ST_DONE    = 3'd1;
	localparam status_t ST_TIMEOUT = 3'd2;
	localparam status_t ST_REFUSED = 3'd3;
	localparam status_t ST_IDLE    = 3'd4;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_CYCLE = 1'b1;

	typedef logic [INDEX_W-1:0] reg_index_t;
	localparam reg_index_t REG_TARGET  = 2'd0;
	localparam reg_index_t REG_MAX     = 2'd1;
	localparam reg_index_t REG_TIMEOUT = 2'd2;
	localparam reg_index_t REG_FACTOR  = 2'd3;

	localparam logic [TARGET_W-1:0] TARGET_RST  = 40'd1000000;
	localparam logic [BRIGHT_W-1:0] MAX_RST     = 8'd255;
	localparam logic [TIME_W-1:0]   TIMEOUT_RST = 32'd300000;
	localparam logic [FACTOR_W-1:0] FACTOR_RST  = 16'd16384;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MUL   = 9'b000000010,
		S_ACC   = 9'b000000100,
		S_EVAL  = 9'b000001000,
		S_SETUP = 9'b000010000,
		S_DIV   = 9'b000100000,
		S_RAMP1 = 9'b001000000,
		S_RAMP2 = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

endpackage

// File: sv/light_dose_exposure_controller.sv
// channel   direction  handshake             payload
// cfg       in         cfg_wr_en             cfg_index, cfg_data
// in        in         in_valid / in_stall   mode, now_ms, devices_ready, sensor_ready,
//                                            light_level
// out       out        out_valid / out_stall status, brightness, sample_rejected, dose
//
// start items and cycles while idle load the result register in S_FIN after the transfer,
// once the output register is free
// a cycle with a sample runs the bit-serial (lux * factor) * ms product in S_MUL, then
// the saturating add, checks, up to 10 trial subtracts for percent and the brightness ramp
// in S_RAMP1 and S_RAMP2
// one item is in work at a time; the next transfer is taken as soon as the result sits
// in the output register, which holds while out_stall is high
// reset puts the registers at their defaults and leaves no exposure running
module light_dose_exposure_controller #(
	parameter int DOSE_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ldec_pkg::INDEX_W-1:0]      cfg_index,
	input  logic [ldec_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [ldec_pkg::TIME_W-1:0]       now_ms,
	input  logic                              devices_ready,
	input  logic                              sensor_ready,
	input  logic [ldec_pkg::LIGHT_W-1:0]      light_level,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ldec_pkg::STATUS_W-1:0]     status,
	output logic [ldec_pkg::BRIGHT_W-1:0]     brightness,
	output logic                              sample_rejected,
	output logic [ldec_pkg::DOSE_W-1:0]       dose
);

	localparam int SUM_W = ((DOSE_BITS > ldec_pkg::DELTA_W) ? DOSE_BITS
		: ldec_pkg::DELTA_W) + 1;
	localparam int CNT_W = $clog2(ldec_pkg::TIME_W);
	localparam logic [DOSE_BITS-1:0] DOSE_LIM = '1;

	ldec_pkg::state_t state_q;

	logic [ldec_pkg::TARGET_W-1:0] target_q;
	logic [ldec_pkg::BRIGHT_W-1:0] max_q;
	logic [ldec_pkg::TIME_W-1:0]   timeout_q;
	logic [ldec_pkg::FACTOR_W-1:0] factor_q;

	logic                          active_q;
	logic [DOSE_BITS-1:0]          dose_sum_q;
	logic [ldec_pkg::TIME_W-1:0]   start_time_q;
	logic [ldec_pkg::TIME_W-1:0]   last_time_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          out_valid_q;

	logic [ldec_pkg::LT_W-1:0]     lt_q;
	logic [ldec_pkg::TIME_W-1:0]   dt_q;
	logic [ldec_pkg::ACC_W-1:0]    acc_q;
	logic [ldec_pkg::TIME_W-1:0]   elapsed_q;
	logic                          sampled_q;
	logic                          rej_q;
	logic [ldec_pkg::REM_W-1:0]    rem_q;
	logic [ldec_pkg::PCT_W-1:0]    pdiff_q;
	logic [ldec_pkg::PROD_W-1:0]   prod_q;
	ldec_pkg::status_t             res_status_q;
	logic [ldec_pkg::BRIGHT_W-1:0] res_bright_q;
	logic                          res_rej_q;
	ldec_pkg::status_t             status_q;
	logic [ldec_pkg::BRIGHT_W-1:0] brightness_q;
	logic                          rej_out_q;
	logic [ldec_pkg::DOSE_W-1:0]   dose_q;

	logic                          in_xfer;
	logic                          out_free;
	logic                          refuse;
	logic                          good_sample;
	logic [ldec_pkg::TARGET_W:0]   mul_top;
	logic [ldec_pkg::DELTA_W-1:0]  delta;
	logic [SUM_W-1:0]              dose_next;
	logic                          reached;
	logic [ldec_pkg::REM_W-1:0]    dose100;
	logic [ldec_pkg::REM_W-1:0]    target90;
	logic [ldec_pkg::QUO_W-1:0]    quo_full;
	logic [ldec_pkg::BRIGHT_W-1:0] quo;
	logic [ldec_pkg::BRIGHT_W-1:0] ramp_v;
	logic [ldec_pkg::BRIGHT_W-1:0] ramp_clamped;

	assign in_stall  = (state_q != ldec_pkg::S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign refuse    = !devices_ready || (target_q == '0);
	assign good_sample = sensor_ready && (light_level != '0);

	// shift-and-add step: add lux*factor into the top when the current ms bit is set
	assign mul_top = {1'b0, acc_q[ldec_pkg::ACC_W-1:ldec_pkg::TIME_W]}
		+ (dt_q[0] ? {1'b0, lt_q} : '0);

	assign delta     = acc_q[ldec_pkg::ACC_W-1:ldec_pkg::FRAC_SH];
	assign dose_next = SUM_W'(dose_sum_q) + SUM_W'(delta);
	assign reached   = dose_sum_q >= DOSE_BITS'(target_q);

	// only used below target, where the dose fits the target width
	assign dose100  = ldec_pkg::REM_W'(dose_sum_q[ldec_pkg::TARGET_W-1:0])
		* ldec_pkg::REM_W'(100);
	assign target90 = ldec_pkg::REM_W'(target_q) * ldec_pkg::REM_W'(90);

	// divide by ten through the reciprocal, exact for the small products seen here
	assign quo_full = ldec_pkg::QUO_W'(prod_q) * ldec_pkg::QUO_W'(ldec_pkg::RECIP10);
	assign quo      = ldec_pkg::BRIGHT_W'(quo_full >> ldec_pkg::RECIP_SH);
	assign ramp_v   = max_q - quo;

	always_comb begin
		if (ramp_v < ldec_pkg::MIN_BRIGHT) begin
			ramp_clamped = ldec_pkg::MIN_BRIGHT;
		end else if (ramp_v > max_q) begin
			ramp_clamped = max_q;
		end else begin
			ramp_clamped = ramp_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= ldec_pkg::TARGET_RST;
			max_q     <= ldec_pkg::MAX_RST;
			timeout_q <= ldec_pkg::TIMEOUT_RST;
			factor_q  <= ldec_pkg::FACTOR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ldec_pkg::REG_TARGET:  target_q  <= cfg_data[ldec_pkg::TARGET_W-1:0];
				ldec_pkg::REG_MAX:     max_q     <= cfg_data[ldec_pkg::BRIGHT_W-1:0];
				ldec_pkg::REG_TIMEOUT: timeout_q <= cfg_data[ldec_pkg::TIME_W-1:0];
				ldec_pkg::REG_FACTOR:  factor_q  <= cfg_data[ldec_pkg::FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ldec_pkg::S_IDLE;
			active_q     <= 1'b0;
			dose_sum_q   <= '0;
			start_time_q <= '0;
			last_time_q  <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// in the final state the output register is reloaded below instead
			if (out_valid_q && !out_stall && (state_q != ldec_pkg::S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ldec_pkg::S_IDLE: begin
					if (in_xfer) begin
						if (mode == ldec_pkg::MODE_START) begin
							if (refuse) begin
								active_q <= 1'b0;
							end else begin
								active_q     <= 1'b1;
								dose_sum_q   <= '0;
								start_time_q <= now_ms;
								last_time_q  <= now_ms;
							end
							state_q <= ldec_pkg::S_FIN;
						end else if (!active_q) begin
							state_q <= ldec_pkg::S_FIN;
						end else if (good_sample) begin
							last_time_q <= now_ms;
							cnt_q       <= '0;
							state_q     <= ldec_pkg::S_MUL;
						end else begin
							state_q <= ldec_pkg::S_EVAL;
						end
					end
				end
				ldec_pkg::S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ldec_pkg::TIME_W - 1)) begin
						state_q <= ldec_pkg::S_ACC;
					end
				end
				ldec_pkg::S_ACC: begin
					if (dose_next > SUM_W'(DOSE_LIM)) begin
						dose_sum_q <= DOSE_LIM;
					end else begin
						dose_sum_q <= dose_next[DOSE_BITS-1:0];
					end
					state_q <= ldec_pkg::S_EVAL;
				end
				ldec_pkg::S_EVAL: begin
					if (sampled_q && reached) begin
						active_q <= 1'b0;
						state_q  <= ldec_pkg::S_FIN;
					end else if (elapsed_q > timeout_q) begin
						active_q <= 1'b0;
						state_q  <= ldec_pkg::S_FIN;
					end else if (reached) begin
						state_q <= ldec_pkg::S_RAMP1;
					end else begin
						state_q <= ldec_pkg::S_SETUP;
					end
				end
				ldec_pkg::S_SETUP: begin
					if (rem_q[ldec_pkg::REM_W-1] || (rem_q == '0)) begin
						state_q <= ldec_pkg::S_FIN;
					end else begin
						state_q <= ldec_pkg::S_DIV;
					end
				end
				ldec_pkg::S_DIV: begin
					if (rem_q < ldec_pkg::REM_W'(target_q)) begin
						state_q <= ldec_pkg::S_RAMP1;
					end
				end
				ldec_pkg::S_RAMP1: state_q <= ldec_pkg::S_RAMP2;
				ldec_pkg::S_RAMP2: state_q <= ldec_pkg::S_FIN;
				ldec_pkg::S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ldec_pkg::S_IDLE;
					end
				end
				default: state_q <= ldec_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ldec_pkg::S_IDLE: begin
				if (in_xfer) begin
					res_rej_q <= 1'b0;
					if (mode == ldec_pkg::MODE_START) begin
						res_status_q <= refuse ? ldec_pkg::ST_REFUSED : ldec_pkg::ST_RUNNING;
						res_bright_q <= refuse ? '0 : max_q;
					end else begin
						res_status_q <= ldec_pkg::ST_IDLE;
						res_bright_q <= '0;
					end
					elapsed_q <= now_ms - start_time_q;
					sampled_q <= good_sample;
					rej_q     <= !good_sample;
					lt_q      <= ldec_pkg::LT_W'(light_level) * ldec_pkg::LT_W'(factor_q);
					dt_q      <= now_ms - last_time_q;
					acc_q     <= '0;
				end
			end
			ldec_pkg::S_MUL: begin
				acc_q <= {mul_top, acc_q[ldec_pkg::TIME_W-1:1]};
				dt_q  <= dt_q >> 1;
			end
			ldec_pkg::S_EVAL: begin
				res_rej_q <= rej_q;
				res_bright_q <= '0;
				pdiff_q   <= ldec_pkg::PCT_FULL_SPAN;
				rem_q     <= dose100 - target90;
				if (sampled_q && reached) begin
					res_status_q <= ldec_pkg::ST_DONE;
				end else if (elapsed_q > timeout_q) begin
					res_status_q <= ldec_pkg::ST_TIMEOUT;
				end else begin
					res_status_q <= ldec_pkg::ST_RUNNING;
				end
			end
			ldec_pkg::S_SETUP: begin
				// ninety percent not passed yet: full drive
				res_bright_q <= max_q;
				pdiff_q      <= '0;
			end
			ldec_pkg::S_DIV: begin
				if (rem_q >= ldec_pkg::REM_W'(target_q)) begin
					rem_q   <= rem_q - ldec_pkg::REM_W'(target_q);
					pdiff_q <= pdiff_q + 1'b1;
				end
			end
			ldec_pkg::S_RAMP1: begin
				prod_q <= ldec_pkg::PROD_W'(pdiff_q)
					* ldec_pkg::PROD_W'(max_q - {2'b00, max_q[ldec_pkg::BRIGHT_W-1:2]});
			end
			ldec_pkg::S_RAMP2: begin
				res_bright_q <= ramp_clamped;
			end
			ldec_pkg::S_FIN: begin
				if (out_free) begin
					status_q     <= res_status_q;
					brightness_q <= res_bright_q;
					rej_out_q    <= res_rej_q;
					dose_q       <= ldec_pkg::DOSE_W'(dose_sum_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign brightness      = brightness_q;
	assign sample_rejected = rej_out_q;
	assign dose            = dose_q;

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (mode == ldec_pkg::MODE_START) && devices_ready && (target_q != '0))
		|=> active_q)
		else $error("accepted start did not arm the exposure");

	a_end_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ldec_pkg::S_FIN) && (res_status_q != ldec_pkg::ST_RUNNING))
		|-> !active_q)
		else $error("exposure still armed with a final status");

	a_dark_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((status == ldec_pkg::ST_DONE) || (status == ldec_pkg::ST_TIMEOUT)
		|| (status == ldec_pkg::ST_REFUSED) || (status == ldec_pkg::ST_IDLE)))
		|-> (brightness == '0))
		else $error("light driven while not running");

	a_reject_scope: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sample_rejected)
		|-> ((status == ldec_pkg::ST_RUNNING) || (status == ldec_pkg::ST_TIMEOUT)))
		else $error("rejected sample flagged outside a running cycle");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import ldec_pkg::*;

	localparam int LIMIT = 1000000;
	localparam logic [DOSE_W-1:0] DOSE_CAP = '1;

	typedef struct {
		logic                mode;
		logic [TIME_W-1:0]   now;
		logic                dev;
		logic                sens;
		logic [LIGHT_W-1:0]  light;
	} drive_t;

	typedef struct {
		status_t             st;
		logic [BRIGHT_W-1:0] br;
		logic                rej;
		logic [DOSE_W-1:0]   dose_val;
	} result_t;

	typedef struct {
		logic                is_cfg;
		reg_index_t          idx;
		logic [CFG_W-1:0]    data;
		drive_t              it;
		logic                has_exp;
		result_t             want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	reg_index_t cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic [TIME_W-1:0] now_ms;
	logic devices_ready;
	logic sensor_ready;
	logic [LIGHT_W-1:0] light_level;
	logic out_valid;
	logic out_stall = 1'b0;
	status_t status;
	logic [BRIGHT_W-1:0] brightness;
	logic sample_rejected;
	logic [DOSE_W-1:0] dose;

	// shadow of the block: registers and exposure state
	logic [TARGET_W-1:0] cfg_target;
	logic [BRIGHT_W-1:0] cfg_max;
	logic [TIME_W-1:0]   cfg_timeout;
	logic [FACTOR_W-1:0] cfg_factor;
	logic                run_on;
	logic [DOSE_W-1:0]   acc_dose;
	logic [TIME_W-1:0]   t_start;
	logic [TIME_W-1:0]   t_last;

	result_t pending_results[$];
	step_t   plan[$];
	int      items_sent = 0;
	int      errors = 0;
	int      send_idle = 20;
	int      recv_idle = 74;
	int      cycle_count = 0;

	light_dose_exposure_controller u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.now_ms(now_ms),
		.devices_ready(devices_ready),
		.sensor_ready(sensor_ready),
		.light_level(light_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.brightness(brightness),
		.sample_rejected(sample_rejected),
		.dose(dose)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	function automatic drive_t make_item(logic m, logic [TIME_W-1:0] t, logic dv, logic sn,
			logic [LIGHT_W-1:0] lx);
		drive_t it;
		it.mode = m;
		it.now = t;
		it.dev = dv;
		it.sens = sn;
		it.light = lx;
		return it;
	endfunction

	function automatic result_t make_result(status_t st, logic [BRIGHT_W-1:0] br, logic rj,
			logic [DOSE_W-1:0] ds);
		result_t r;
		r.st = st;
		r.br = br;
		r.rej = rj;
		r.dose_val = ds;
		return r;
	endfunction

	function automatic step_t cfg_row(reg_index_t i, logic [CFG_W-1:0] d);
		step_t s;
		s.is_cfg = 1'b1;
		s.idx = i;
		s.data = d;
		s.it = make_item(MODE_CYCLE, '0, 1'b0, 1'b0, '0);
		s.has_exp = 1'b0;
		s.want = make_result(ST_IDLE, '0, 1'b0, '0);
		return s;
	endfunction

	function automatic step_t item_row(drive_t it);
		step_t s;
		s = cfg_row(REG_TARGET, '0);
		s.is_cfg = 1'b0;
		s.it = it;
		return s;
	endfunction

	function automatic step_t checked_row(drive_t it, result_t r);
		step_t s;
		s = item_row(it);
		s.has_exp = 1'b1;
		s.want = r;
		return s;
	endfunction

	// percent ramp over the last tenth of the target
	function automatic logic [BRIGHT_W-1:0] ramp_level();
		int m;
		int pct;
		int v;
		m = cfg_max;
		if (acc_dose >= 48'(cfg_target)) begin
			pct = 100;
		end else if (64'(acc_dose) * 10 <= 64'(cfg_target) * 9) begin
			return cfg_max;
		end else begin
			pct = int'(64'(acc_dose) * 100 / 64'(cfg_target));
		end
		v = m - (pct - 90) * (m - m / 4) / 10;
		if (v < 10)
			v = 10;
		if (v > m)
			v = m;
		return 8'(v);
	endfunction

	function automatic result_t exposure_step(drive_t it);
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] dt;
		logic [71:0]       prod;
		logic [63:0]       sum;
		logic              rej;
		rej = 1'b0;
		if (it.mode == MODE_START) begin
			if (!it.dev || cfg_target == '0) begin
				run_on = 1'b0;
				return make_result(ST_REFUSED, '0, 1'b0, acc_dose);
			end
			run_on = 1'b1;
			acc_dose = '0;
			t_start = it.now;
			t_last = it.now;
			return make_result(ST_RUNNING, cfg_max, 1'b0, '0);
		end
		if (!run_on)
			return make_result(ST_IDLE, '0, 1'b0, acc_dose);
		elapsed = it.now - t_start;
		if (it.sens && it.light != '0) begin
			dt = it.now - t_last;
			prod = 72'(it.light) * 72'(dt) * 72'(cfg_factor);
			sum = 64'(acc_dose) + 64'(prod >> FRAC_SH);
			acc_dose = (sum > 64'(DOSE_CAP)) ? DOSE_CAP : sum[DOSE_W-1:0];
			t_last = it.now;
			if (acc_dose >= 48'(cfg_target)) begin
				run_on = 1'b0;
				return make_result(ST_DONE, '0, 1'b0, acc_dose);
			end
		end else begin
			rej = 1'b1;
		end
		if (elapsed > cfg_timeout) begin
			run_on = 1'b0;
			return make_result(ST_TIMEOUT, '0, rej, acc_dose);
		end
		return make_result(ST_RUNNING, ramp_level(), rej, acc_dose);
	endfunction

	// entered and left at a falling edge
	task automatic push_item(input drive_t it, input logic has_exp, input result_t want);
		result_t r;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		now_ms <= it.now;
		devices_ready <= it.dev;
		sensor_ready <= it.sens;
		light_level <= it.light;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = exposure_step(it);
		if (has_exp)
			r = want;
		pending_results.push_back(r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t i, input logic [CFG_W-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= i;
		cfg_data <= d;
		case (i)
			REG_TARGET:  cfg_target = d[TARGET_W-1:0];
			REG_MAX:     cfg_max = d[BRIGHT_W-1:0];
			REG_TIMEOUT: cfg_timeout = d[TIME_W-1:0];
			REG_FACTOR:  cfg_factor = d[FACTOR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_config(input logic [TARGET_W-1:0] tgt, input logic [BRIGHT_W-1:0] mx,
			input logic [TIME_W-1:0] tmo, input logic [FACTOR_W-1:0] fac);
		settle();
		write_reg(REG_TARGET, CFG_W'(tgt));
		write_reg(REG_MAX, CFG_W'(mx));
		write_reg(REG_TIMEOUT, CFG_W'(tmo));
		write_reg(REG_FACTOR, CFG_W'(fac));
	endtask

	// mostly whole exposures sized to finish in a few dozen samples, plus noise
	task automatic random_traffic(input int count);
		int stop_at;
		int k;
		int n;
		logic [63:0] dt_max;
		logic [63:0] dt_avg;
		logic [63:0] lbase;
		logic [63:0] lx;
		logic [63:0] fac;
		logic [TIME_W-1:0] t;
		result_t none;
		none = make_result(ST_IDLE, '0, 1'b0, '0);
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 12) begin
				push_item(make_item(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
					1'($urandom_range(1)), 24'($urandom) >> $urandom_range(23)), 1'b0, none);
			end else begin
				k = $urandom_range(1, 24);
				case ($urandom_range(2))
					0: dt_max = 64'($urandom_range(1, 16));
					1: dt_max = 64'($urandom_range(1, 2000));
					default: dt_max = 64'(cfg_timeout) / k * 3 / 2 + 1;
				endcase
				if (dt_max > 64'hFFFF_FFFF)
					dt_max = 64'hFFFF_FFFF;
				dt_avg = dt_max / 2 + 1;
				fac = (cfg_factor == '0) ? 64'd1 : 64'(cfg_factor);
				lbase = (64'(cfg_target) << FRAC_SH) / (64'(k) * dt_avg * fac);
				if (lbase == 0)
					lbase = 1;
				if (lbase > 64'hFF_FFFF)
					lbase = 64'hFF_FFFF;
				t = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(5000) : $urandom;
				push_item(make_item(MODE_START, t, $urandom_range(99) >= 5,
					1'($urandom_range(1)), 24'($urandom)), 1'b0, none);
				n = 0;
				while (run_on && n < 2 * k + 4) begin
					t = t + $urandom_range(32'(dt_max));
					lx = lbase * $urandom_range(75, 125) / 100;
					if (lx > 64'hFF_FFFF)
						lx = 64'hFF_FFFF;
					if ($urandom_range(99) < 5)
						lx = 0;
					if ($urandom_range(99) < 4)
						push_item(make_item(MODE_START, t, $urandom_range(99) >= 20,
							1'($urandom_range(1)), 24'(lx)), 1'b0, none);
					else
						push_item(make_item(MODE_CYCLE, t, 1'($urandom_range(1)),
							$urandom_range(99) >= 10, 24'(lx)), 1'b0, none);
					n++;
				end
				if ($urandom_range(3) == 0)
					push_item(make_item(MODE_CYCLE, t + 1, 1'($urandom_range(1)), 1'b1,
						24'(lbase)), 1'b0, none);
			end
		end
	endtask

	always @(posedge clk) begin : check_out
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = make_result(status, brightness, sample_rejected, dose);
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer: st=%0d br=%0d rej=%0d dose=%0d",
						got.st, got.br, got.rej, got.dose_val);
			end else begin
				want = pending_results.pop_front();
				if (got.st !== want.st || got.br !== want.br || got.rej !== want.rej ||
						got.dose_val !== want.dose_val) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: want st=%0d br=%0d rej=%0d dose=%0d, got st=%0d br=%0d rej=%0d dose=%0d",
							want.st, want.br, want.rej, want.dose_val,
							got.st, got.br, got.rej, got.dose_val);
				end
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: errors");
		$finish;
	end

	initial begin
		int seg;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_TARGET;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_START;
		now_ms = '0;
		devices_ready = 1'b0;
		sensor_ready = 1'b0;
		light_level = '0;
		cfg_target = TARGET_RST;
		cfg_max = MAX_RST;
		cfg_timeout = TIMEOUT_RST;
		cfg_factor = FACTOR_RST;
		run_on = 1'b0;
		acc_dose = '0;
		t_start = '0;
		t_last = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// defaults after reset: 1000 lux over 1000 ms is exactly the target
		plan.push_back(checked_row(make_item(MODE_CYCLE, 0, 1, 1, 24'hFF_FFFF),
			make_result(ST_IDLE, 0, 0, 0)));
		plan.push_back(checked_row(make_item(MODE_START, 100, 0, 1, 0),
			make_result(ST_REFUSED, 0, 0, 0)));
		plan.push_back(checked_row(make_item(MODE_START, 1000, 1, 0, 0),
			make_result(ST_RUNNING, 255, 0, 0)));
		plan.push_back(checked_row(make_item(MODE_CYCLE, 1010, 1, 0, 256000),
			make_result(ST_RUNNING, 255, 1, 0)));
		plan.push_back(checked_row(make_item(MODE_CYCLE, 1020, 1, 1, 0),
			make_result(ST_RUNNING, 255, 1, 0)));
		plan.push_back(checked_row(make_item(MODE_CYCLE, 2000, 0, 1, 256000),
			make_result(ST_DONE, 0, 0, 1000000)));
		plan.push_back(checked_row(make_item(MODE_CYCLE, 2100, 1, 1, 256000),
			make_result(ST_IDLE, 0, 0, 1000000)));
		// timestamps wrap, ramp past ninety percent, then timeout
		plan.push_back(item_row(make_item(MODE_START, 32'hFFFF_FF00, 1, 1, 0)));
		plan.push_back(item_row(make_item(MODE_CYCLE, 32'h0000_0100, 1, 1, 256000)));
		plan.push_back(item_row(make_item(MODE_CYCLE, 32'h0000_0290, 1, 1, 256000)));
		plan.push_back(item_row(make_item(MODE_CYCLE, 32'h0000_02E0, 1, 1, 256000)));
		plan.push_back(item_row(make_item(MODE_CYCLE, 32'd299745, 1, 0, 256000)));
		// restart while running, refusal keeps the dose
		plan.push_back(item_row(make_item(MODE_START, 5000, 1, 0, 0)));
		plan.push_back(item_row(make_item(MODE_CYCLE, 5100, 1, 1, 25600)));
		plan.push_back(checked_row(make_item(MODE_START, 5200, 1, 1, 25600),
			make_result(ST_RUNNING, 255, 0, 0)));
		plan.push_back(item_row(make_item(MODE_CYCLE, 5300, 1, 1, 25600)));
		plan.push_back(checked_row(make_item(MODE_START, 5400, 0, 1, 0),
			make_result(ST_REFUSED, 0, 0, 10000)));
		plan.push_back(checked_row(make_item(MODE_CYCLE, 5500, 1, 1, 25600),
			make_result(ST_IDLE, 0, 0, 10000)));
		// largest sample saturates the dose
		plan.push_back(cfg_row(REG_MAX, 10));
		plan.push_back(cfg_row(REG_FACTOR, 16'hFFFF));
		plan.push_back(cfg_row(REG_TARGET, 40'hFF_FFFF_FFFF));
		plan.push_back(cfg_row(REG_TIMEOUT, 0));
		plan.push_back(checked_row(make_item(MODE_START, 0, 1, 0, 0),
			make_result(ST_RUNNING, 10, 0, 0)));
		plan.push_back(checked_row(make_item(MODE_CYCLE, 0, 1, 1, 1),
			make_result(ST_RUNNING, 10, 0, 0)));
		plan.push_back(checked_row(make_item(MODE_CYCLE, 32'hFFFF_FFFF, 1, 1, 24'hFF_FFFF),
			make_result(ST_DONE, 0, 0, DOSE_CAP)));
		// low max brightness: ramp is clamped to the floor
		plan.push_back(cfg_row(REG_TARGET, 1000));
		plan.push_back(cfg_row(REG_FACTOR, 16384));
		plan.push_back(cfg_row(REG_TIMEOUT, 32'hFFFF_FFFF));
		plan.push_back(item_row(make_item(MODE_START, 100, 1, 0, 0)));
		plan.push_back(item_row(make_item(MODE_CYCLE, 101, 1, 1, 243200)));
		plan.push_back(item_row(make_item(MODE_CYCLE, 102, 1, 0, 243200)));
		plan.push_back(item_row(make_item(MODE_CYCLE, 103, 1, 1, 15360)));
		plan.push_back(cfg_row(REG_TIMEOUT, 0));
		plan.push_back(item_row(make_item(MODE_START, 7, 1, 0, 0)));
		plan.push_back(checked_row(make_item(MODE_CYCLE, 8, 1, 0, 500),
			make_result(ST_TIMEOUT, 0, 1, 0)));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				push_item(plan[i].it, plan[i].has_exp, plan[i].want);
			end
		end

		for (seg = 0; seg < 6; seg++) begin
			if (seg == 2) begin
				send_idle = 74;
				recv_idle = 20;
			end
			if (seg == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (seg)
				0: load_config(TARGET_RST, MAX_RST, TIMEOUT_RST, FACTOR_RST);
				1: load_config(40'd1, 8'd10, 32'd0, 16'd0);
				2: load_config('1, 8'd255, '1, '1);
				default: load_config(40'({$urandom, $urandom} >> $urandom_range(24, 63)) | 40'd1,
					8'($urandom_range(10, 255)),
					$urandom_range(1) ? $urandom_range(100, 1000000) : $urandom,
					16'($urandom_range(0, 65535)));
			endcase
			random_traffic(130);
		end

		settle();
		repeat (60) @(negedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
